>>> src/bu2x_pkg.sv
// Shared types and constants for the 2x bilinear upsampler.
// No dependencies; imported by every module of the block.
`default_nettype none
package bu2x_pkg;

    localparam int MAX_COLS    = 1024;
    localparam int MAX_ROWS    = 1024;
    localparam int SAMPLE_BITS = 16;

    localparam int IN_W    = 16;  // sample field width
    localparam int REG_W   = 11;  // size register width
    localparam int COORD_W = 11;
    localparam int VALUE_W = 18;
    localparam int COL_W   = $clog2(MAX_COLS);
    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int TDATA_W = ((2 * COORD_W + VALUE_W + 7) / 8) * 8;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROWS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_COLS = CFG_IDX_W'(1);

    // output point kind, in emission order
    typedef enum logic [1:0] {
        PH_KEEP,
        PH_HORZ,
        PH_VERT,
        PH_CENT
    } phase_t;

    // one accepted source sample with its neighbourhood
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic [SAMPLE_BITS-1:0] left;
        logic [SAMPLE_BITS-1:0] upper_left;
        logic [ROW_W-1:0]       row;
        logic [COL_W-1:0]       col;
        logic                   last_frame;
    } item_t;

    typedef struct packed {
        logic busy;
        logic ready;
    } emit_stat_t;

    // size register to effective size, held to 2..max
    function automatic logic [REG_W-1:0] clamp_size(input logic [REG_W-1:0] v,
                                                    input logic [REG_W-1:0] maxv);
        logic [REG_W-1:0] r;
        r = v;
        if (v < REG_W'(2))
            r = REG_W'(2);
        else if (v > maxv)
            r = maxv;
        return r;
    endfunction

endpackage
`default_nettype wire

>>> src/bu2x_line_ram.sv
// Previous-row line store: single port, read-before-write, registered read.
// Depends on bu2x_pkg for depth and sample width.
`default_nettype none
module bu2x_line_ram (
    input  wire logic                             clk,
    input  wire logic                             en,
    input  wire logic [bu2x_pkg::COL_W-1:0]       addr,
    input  wire logic [bu2x_pkg::SAMPLE_BITS-1:0] wdata,
    output logic      [bu2x_pkg::SAMPLE_BITS-1:0] rdata
);
    import bu2x_pkg::*;

    logic [SAMPLE_BITS-1:0] mem [MAX_COLS];
    logic [SAMPLE_BITS-1:0] rdata_reg;

    // old entry comes out while the new sample goes in
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata_reg  <= mem[addr];
            mem[addr]  <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

>>> src/bu2x_emit.sv
// Point sequencer (needs bu2x_pkg): turns one source item into up to
// four beats, one per cycle unless stalled, through a registered output.
`default_nettype none
module bu2x_emit (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             load,
    input  wire bu2x_pkg::item_t                  item,
    input  wire logic [bu2x_pkg::SAMPLE_BITS-1:0] up,
    output bu2x_pkg::emit_stat_t                  stat,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [bu2x_pkg::TDATA_W-1:0]          m_tdata,
    output logic                                  m_tlast,
    output logic                                  m_tuser
);
    import bu2x_pkg::*;

    logic                busy_reg;
    phase_t              phase_reg;
    phase_t              phase_next;
    item_t               it_reg;
    logic                more;
    logic                has_left;
    logic                has_up;
    logic                out_load;
    logic                fire;
    logic                done;
    logic [COORD_W-1:0]  r2;
    logic [COORD_W-1:0]  c2;
    logic [COORD_W-1:0]  row_val;
    logic [COORD_W-1:0]  col_val;
    logic [VALUE_W-1:0]  s_q;
    logic [VALUE_W-1:0]  l_q;
    logic [VALUE_W-1:0]  u_q;
    logic [VALUE_W-1:0]  ul_q;
    logic [VALUE_W-1:0]  value;

    logic                m_tvalid_reg;
    logic [COORD_W-1:0]  row_reg;
    logic [COORD_W-1:0]  col_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic                last_run_reg;
    logic                last_frame_reg;

    assign has_left = (it_reg.col != '0);
    assign has_up   = (it_reg.row != '0);

    always_comb
    begin
        phase_next = PH_KEEP;
        more       = 1'b0;
        unique case (phase_reg)
            PH_KEEP:
            begin
                if (has_left)
                begin
                    phase_next = PH_HORZ;
                    more       = 1'b1;
                end
                else if (has_up)
                begin
                    phase_next = PH_VERT;
                    more       = 1'b1;
                end
            end
            PH_HORZ:
            begin
                if (has_up)
                begin
                    phase_next = PH_VERT;
                    more       = 1'b1;
                end
            end
            PH_VERT:
            begin
                if (has_left)
                begin
                    phase_next = PH_CENT;
                    more       = 1'b1;
                end
            end
            PH_CENT:
            begin
                phase_next = PH_KEEP;
                more       = 1'b0;
            end
            default:
            begin
                phase_next = PH_KEEP;
                more       = 1'b0;
            end
        endcase
    end

    assign s_q  = VALUE_W'(it_reg.sample);
    assign l_q  = VALUE_W'(it_reg.left);
    assign u_q  = VALUE_W'(up);
    assign ul_q = VALUE_W'(it_reg.upper_left);
    assign r2   = COORD_W'({it_reg.row, 1'b0});
    assign c2   = COORD_W'({it_reg.col, 1'b0});

    always_comb
    begin
        value   = s_q << 2;
        row_val = r2;
        col_val = c2;
        unique case (phase_reg)
            PH_KEEP:
            begin
                value = s_q << 2;
            end
            PH_HORZ:
            begin
                value   = (l_q + s_q) << 1;
                col_val = c2 - COORD_W'(1);
            end
            PH_VERT:
            begin
                value   = (u_q + s_q) << 1;
                row_val = r2 - COORD_W'(1);
            end
            PH_CENT:
            begin
                value   = ul_q + u_q + l_q + s_q;
                row_val = r2 - COORD_W'(1);
                col_val = c2 - COORD_W'(1);
            end
            default:
            begin
                value = s_q << 2;
            end
        endcase
    end

    assign out_load   = !m_tvalid_reg || m_tready;
    assign fire       = busy_reg && out_load;
    assign done       = fire && !more;
    assign stat.busy  = busy_reg;
    assign stat.ready = !busy_reg || done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            phase_reg    <= PH_KEEP;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                busy_reg  <= 1'b1;
                phase_reg <= PH_KEEP;
            end
            else if (done)
            begin
                busy_reg  <= 1'b0;
                phase_reg <= PH_KEEP;
            end
            else if (fire)
            begin
                phase_reg <= phase_next;
            end
            if (out_load)
                m_tvalid_reg <= fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            it_reg <= item;
        if (fire)
        begin
            row_reg        <= row_val;
            col_reg        <= col_val;
            value_reg      <= value;
            last_run_reg   <= !more;
            last_frame_reg <= !more && it_reg.last_frame;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TDATA_W'({value_reg, col_reg, row_reg});
    assign m_tlast  = last_run_reg;
    assign m_tuser  = last_frame_reg;

endmodule
`default_nettype wire

>>> src/bilinear_upsample_2x_core.sv
// Top level of the 2x bilinear upsampler: position counters, size registers,
// line store and point sequencer. Depends on bu2x_pkg, bu2x_line_ram, bu2x_emit.
//
// Usage
//   Slave stream s_*: one source sample per beat, raster order, low 16 bits.
//   Master stream m_*: one grid point per beat. tdata = {value_quarters,
//   out_col, out_row}, MSB first; tlast marks the last point of a source
//   sample, tuser the last point of the whole image.
//   Config port: cfg_we/cfg_index/cfg_data writes image_rows (index 0) or
//   image_cols (index 1); any such write restarts the frame at (0,0).
//   Sizes below 2 act as 2, above the maximum act as the maximum.
//   Write sizes only while the block is idle.
// Timing
//   A sample makes one point at (0,0), two on the first row or column and
//   four elsewhere, all via the single output register. The next sample is
//   taken in the cycle the last point of the current one enters the output
//   register. The sample itself is registered in the sequencer first. The
//   line store is read and written at the same address in the accept cycle
//   (old value out), so no forwarding is needed.
// Reset
//   Control clears; sizes go to 2x2, position to (0,0). Line store contents
//   stay undefined; row 0 never uses them.
// Stall
//   With m_tready low the output beat holds, the sequencer waits and
//   s_tready drops until the current sample's last point is registered.
`default_nettype none
module bilinear_upsample_2x_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [bu2x_pkg::IN_W-1:0]         s_tdata,   // [15:0] sample
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [10:0] out_row, [21:11] out_col, [39:22] value_quarters
    output logic [bu2x_pkg::TDATA_W-1:0]           m_tdata,
    output logic                                   m_tlast,   // last_of_run
    output logic                                   m_tuser,   // [0] last_of_frame
    input  wire logic                              cfg_we,
    input  wire logic [bu2x_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bu2x_pkg::REG_W-1:0]        cfg_data
);
    import bu2x_pkg::*;

    logic [REG_W-1:0]       rows_reg;
    logic [REG_W-1:0]       cols_reg;
    logic [ROW_W-1:0]       row_reg;
    logic [COL_W-1:0]       col_reg;
    logic [SAMPLE_BITS-1:0] left_reg;
    logic [REG_W-1:0]       rows_eff;
    logic [REG_W-1:0]       cols_eff;
    logic                   end_col;
    logic                   end_row;
    logic                   accept;
    logic [SAMPLE_BITS-1:0] s_in;
    logic [SAMPLE_BITS-1:0] up;
    item_t                  item;
    emit_stat_t             stat;

    assign rows_eff = clamp_size(rows_reg, REG_W'(MAX_ROWS));
    assign cols_eff = clamp_size(cols_reg, REG_W'(MAX_COLS));
    assign end_col  = (REG_W'(col_reg) == cols_eff - REG_W'(1));
    assign end_row  = (REG_W'(row_reg) == rows_eff - REG_W'(1));

    assign s_tready = stat.ready;
    assign accept   = s_tvalid && s_tready;
    assign s_in     = s_tdata[SAMPLE_BITS-1:0];

    // the store's read register still holds the previous sample's upper
    // neighbour, which is this sample's upper-left one
    assign item.sample     = s_in;
    assign item.left       = left_reg;
    assign item.upper_left = up;
    assign item.row        = row_reg;
    assign item.col        = col_reg;
    assign item.last_frame = end_row && end_col;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= REG_W'(2);
            cols_reg <= REG_W'(2);
            row_reg  <= '0;
            col_reg  <= '0;
        end
        else if (cfg_we && (cfg_index == REG_ROWS || cfg_index == REG_COLS))
        begin
            if (cfg_index == REG_ROWS)
                rows_reg <= cfg_data;
            else
                cols_reg <= cfg_data;
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (accept)
        begin
            if (!end_col)
                col_reg <= col_reg + COL_W'(1);
            else
            begin
                col_reg <= '0;
                row_reg <= end_row ? '0 : row_reg + ROW_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            left_reg <= s_in;
    end

    bu2x_line_ram u_line_ram (
        .clk   (clk),
        .en    (accept),
        .addr  (col_reg),
        .wdata (s_in),
        .rdata (up)
    );

    bu2x_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .item     (item),
        .up       (up),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // end of frame is always also end of a sample's run
    a_frame_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (!m_tuser || m_tlast))
        else $error("last_of_frame without last_of_run");

    // a kept sample (even row, even column) is a whole multiple of four
    a_kept_whole: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[0] && !m_tdata[COORD_W])
            |-> (m_tdata[2*COORD_W+1:2*COORD_W] == 2'b00))
        else $error("kept sample carries a fraction");

    // an accepted sample always occupies the sequencer next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> stat.busy)
        else $error("sequencer idle after accept");

    // a size write restarts the frame
    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && (cfg_index == REG_ROWS || cfg_index == REG_COLS))
            |=> (row_reg == '0 && col_reg == '0))
        else $error("frame not restarted by size write");

endmodule
`default_nettype wire

>>> tb/sv/tb_bilinear_upsample_2x_core.sv
// Self-checking testbench for bilinear_upsample_2x_core: a directed script, then
// random frames of many sizes, with random gaps on both streams.
// Depends on bu2x_pkg and the RTL of the core only.
module tb_bilinear_upsample_2x_core;
    timeunit 1ns;
    timeprecision 1ps;

    import bu2x_pkg::*;

    // ---------------------------------------------------------------------
    // Run control
    // ---------------------------------------------------------------------
    localparam int LIMIT_CYCLES  = 400000;   // generous: ~330 samples, 4 points, long stalls
    localparam int DRAIN_CYCLES  = 8;        // output register plus margin
    localparam int RANDOM_ITEMS  = 310;
    localparam int LONG_HOLD     = 250;      // one long receiver hold-off
    localparam int HOLD_AFTER    = 120;      // samples accepted before the hold-off

    // register indexes that the core does not decode, and a filler for samples
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B   = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] IDX_DONT_CARE = REG_ROWS;

    // ---------------------------------------------------------------------
    // DUT signals; every input known from time zero
    // ---------------------------------------------------------------------
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;
    logic                 m_tlast;
    logic                 m_tuser;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [REG_W-1:0]     cfg_data  = '0;

    bilinear_upsample_2x_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),     // [15:0] sample
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),     // [10:0] out_row, [21:11] out_col, [39:22] value_quarters
        .m_tlast   (m_tlast),     // last_of_run
        .m_tuser   (m_tuser),     // [0] last_of_frame
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Expected grid points
    // ---------------------------------------------------------------------
    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [VALUE_W-1:0] value;
        logic               last_run;
        logic               last_frame;
    } grid_point_t;

    grid_point_t expected_points [$];   // oldest first
    grid_point_t run_points [$];        // points of the sample just predicted

    // Predictor state: own copy of the size registers, line store and position
    logic [REG_W-1:0]       size_rows = REG_W'(2);
    logic [REG_W-1:0]       size_cols = REG_W'(2);
    logic [IN_W-1:0]        line_store [MAX_COLS];
    logic [IN_W-1:0]        left_px   = '0;
    logic [IN_W-1:0]        above_left_px = '0;
    int                     pos_row   = 0;
    int                     pos_col   = 0;

    int  mismatch_count   = 0;
    int  samples_accepted = 0;
    int  cycle_count      = 0;
    bit  calm             = 1'b0;    // phase with no idling on either side
    bit  long_hold_done   = 1'b0;

    // Size register to the size in force: held to 2..limit
    function automatic int effective_size(input logic [REG_W-1:0] v, input int limit);
        int r;
        r = int'(v);
        if (r < 2)
            r = 2;
        else if (r > limit)
            r = limit;
        return r;
    endfunction

    // Points caused by one source sample, in emission order, into run_points;
    // advances the raster position and the neighbourhood.
    task automatic predict_points(input logic [IN_W-1:0] px);
        int            rows_now;
        int            cols_now;
        int            r;
        int            c;
        logic [IN_W-1:0] above;
        grid_point_t   pt;
        rows_now = effective_size(size_rows, MAX_ROWS);
        cols_now = effective_size(size_cols, MAX_COLS);
        r = pos_row;
        c = pos_col;
        if (r >= rows_now || c >= cols_now)
        begin
            r = 0;
            c = 0;
        end
        above = line_store[c];
        run_points.delete();

        // kept sample
        pt = '0;
        pt.row   = COORD_W'(2 * r);
        pt.col   = COORD_W'(2 * c);
        pt.value = VALUE_W'(px) * VALUE_W'(4);
        run_points.push_back(pt);
        // horizontal midpoint to the left
        if (c > 0)
        begin
            pt.col   = COORD_W'(2 * c - 1);
            pt.value = (VALUE_W'(left_px) + VALUE_W'(px)) * VALUE_W'(2);
            run_points.push_back(pt);
        end
        // vertical midpoint above
        if (r > 0)
        begin
            pt.row   = COORD_W'(2 * r - 1);
            pt.col   = COORD_W'(2 * c);
            pt.value = (VALUE_W'(above) + VALUE_W'(px)) * VALUE_W'(2);
            run_points.push_back(pt);
        end
        // centre point, mean of four
        if (r > 0 && c > 0)
        begin
            pt.row   = COORD_W'(2 * r - 1);
            pt.col   = COORD_W'(2 * c - 1);
            pt.value = VALUE_W'(above_left_px) + VALUE_W'(above)
                     + VALUE_W'(left_px) + VALUE_W'(px);
            run_points.push_back(pt);
        end
        run_points[run_points.size() - 1].last_run   = 1'b1;
        run_points[run_points.size() - 1].last_frame =
            (r == rows_now - 1) && (c == cols_now - 1);

        above_left_px = above;
        line_store[c] = px;
        left_px       = px;
        if (c + 1 < cols_now)
        begin
            pos_row = r;
            pos_col = c + 1;
        end
        else if (r + 1 < rows_now)
        begin
            pos_row = r + 1;
            pos_col = 0;
        end
        else
        begin
            pos_row = 0;
            pos_col = 0;
        end
    endtask

    // ---------------------------------------------------------------------
    // Idling: mostly none or short, now and then long
    // ---------------------------------------------------------------------
    function automatic int idle_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        else if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [IN_W-1:0] pick_sample();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return '0;
        else if (pick == 1)
            return '1;
        return IN_W'($urandom_range(0, 65535));
    endfunction

    // ---------------------------------------------------------------------
    // Stimulus tasks; each is entered just after a rising edge
    // ---------------------------------------------------------------------

    // Offer one sample beat; predict its points once the beat is taken.
    // A pinned row replaces the kept point with hand-written values.
    task automatic offer_sample(input logic [IN_W-1:0] px, input bit pinned,
                                input logic [COORD_W-1:0] pin_row,
                                input logic [COORD_W-1:0] pin_col,
                                input logic [VALUE_W-1:0] pin_value);
        int gap;
        gap = calm ? 0 : idle_length();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        // beat taken at this edge
        predict_points(px);
        if (pinned)
        begin
            run_points[0].row   = pin_row;
            run_points[0].col   = pin_col;
            run_points[0].value = pin_value;
        end
        foreach (run_points[k])
            expected_points.push_back(run_points[k]);
        samples_accepted++;
    endtask

    // Stop offering, let every expected point out, then let the pipe settle
    task automatic drain_block();
        s_tvalid <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Register write, only with the block idle
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [REG_W-1:0] data);
        drain_block();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        // written at this edge; any decoded write restarts the frame
        if (idx == REG_ROWS)
        begin
            size_rows = data;
            pos_row   = 0;
            pos_col   = 0;
        end
        else if (idx == REG_COLS)
        begin
            size_cols = data;
            pos_row   = 0;
            pos_col   = 0;
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_phase(input logic [REG_W-1:0] rows, input logic [REG_W-1:0] cols,
                             input int count);
        write_register(REG_ROWS, rows);
        write_register(REG_COLS, cols);
        repeat (count)
            offer_sample(pick_sample(), 1'b0, '0, '0, '0);
    endtask

    // ---------------------------------------------------------------------
    // Directed script
    // ---------------------------------------------------------------------
    typedef enum logic {
        STEP_SAMPLE,
        STEP_WRITE
    } step_kind_t;

    typedef struct packed {
        step_kind_t           kind;
        logic [CFG_IDX_W-1:0] index;
        logic [IN_W-1:0]      value;     // sample, or register data
        logic                 pinned;    // kept point typed in below
        logic [COORD_W-1:0]   pin_row;
        logic [COORD_W-1:0]   pin_col;
        logic [VALUE_W-1:0]   pin_value;
    } script_step_t;

    localparam int SCRIPT_LEN = 29;
    localparam script_step_t SCRIPT [SCRIPT_LEN] = '{
        // 2x2 after reset, all ones: every point is full scale
        '{STEP_SAMPLE, IDX_DONT_CARE, 16'hFFFF, 1'b1, 11'd0, 11'd0, 18'h3FFFC},
        '{STEP_SAMPLE, IDX_DONT_CARE, 16'hFFFF, 1'b1, 11'd0, 11'd2, 18'h3FFFC},
        '{STEP_SAMPLE, IDX_DONT_CARE, 16'hFFFF, 1'b1, 11'd2, 11'd0, 18'h3FFFC},
        '{STEP_SAMPLE, IDX_DONT_CARE, 16'hFFFF, 1'b1, 11'd2, 11'd2, 18'h3FFFC},
        // wrap to a new frame, mixed extremes
        '{STEP_SAMPLE, IDX_DONT_CARE, 16'h0000, 1'b1, 11'd0, 11'd0, 18'h00000},
        '{STEP_SAMPLE, IDX_DONT_CARE, 16'h8000, 1'b0, '0, '0, '0},
        '{STEP_SAMPLE, IDX_DONT_CARE, 16'h0001, 1'b0, '0, '0, '0},
        '{STEP_SAMPLE, IDX_DONT_CARE, 16'h7FFF, 1'b0, '0, '0, '0},
        // 3x3 checkerboard
        '{STEP_WRITE,  REG_ROWS,      16'd3,    1'b0, '0, '0, '0},
        '{STEP_WRITE,  REG_COLS,      16'd3,    1'b0, '0, '0, '0},
        '{STEP_SAMPLE, IDX_DONT_CARE, 16'h0000, 1'b1, 11'd0, 11'd0, 18'h00000},
        '{STEP_SAMPLE, IDX_DONT_CARE, 16'hFFFF, 1'b0, '0, '0, '0},
        '{STEP_SAMPLE, IDX_DONT_CARE, 16'h0000, 1'b0, '0, '0, '0},
        '{STEP_SAMPLE, IDX_DONT_CARE, 16'hFFFF, 1'b0, '0, '0, '0},
        // undecoded index mid-frame: no effect, frame carries on
        '{STEP_WRITE,  REG_SPARE_A,   16'h07FF, 1'b0, '0, '0, '0},
        '{STEP_SAMPLE, IDX_DONT_CARE, 16'h0000, 1'b0, '0, '0, '0},
        '{STEP_SAMPLE, IDX_DONT_CARE, 16'hFFFF, 1'b0, '0, '0, '0},
        '{STEP_WRITE,  REG_SPARE_B,   16'h0000, 1'b0, '0, '0, '0},
        '{STEP_SAMPLE, IDX_DONT_CARE, 16'h0000, 1'b0, '0, '0, '0},
        '{STEP_SAMPLE, IDX_DONT_CARE, 16'hFFFF, 1'b0, '0, '0, '0},
        '{STEP_SAMPLE, IDX_DONT_CARE, 16'h0000, 1'b0, '0, '0, '0},
        '{STEP_SAMPLE, IDX_DONT_CARE, 16'h1234, 1'b0, '0, '0, '0},
        '{STEP_SAMPLE, IDX_DONT_CARE, 16'hABCD, 1'b0, '0, '0, '0},
        // sizes below two act as two; the rows write restarts mid-frame
        '{STEP_WRITE,  REG_ROWS,      16'd1,    1'b0, '0, '0, '0},
        '{STEP_WRITE,  REG_COLS,      16'd0,    1'b0, '0, '0, '0},
        '{STEP_SAMPLE, IDX_DONT_CARE, 16'h5555, 1'b1, 11'd0, 11'd0, 18'h15554},
        '{STEP_SAMPLE, IDX_DONT_CARE, 16'hAAAA, 1'b0, '0, '0, '0},
        '{STEP_SAMPLE, IDX_DONT_CARE, 16'h0F0F, 1'b0, '0, '0, '0},
        '{STEP_SAMPLE, IDX_DONT_CARE, 16'hF0F0, 1'b0, '0, '0, '0}
    };

    // ---------------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < 100)
            $display("ERROR @%0t: %s got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Output beat scoreboard; values seen are those before the edge
    always @(posedge clk)
    begin : point_check
        grid_point_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_points.size() == 0)
                report_mismatch("unexpected point beat, row", int'(m_tdata[10:0]), 0);
            else
            begin
                want = expected_points.pop_front();
                if (m_tdata[10:0] !== want.row)
                    report_mismatch("out_row", int'(m_tdata[10:0]), int'(want.row));
                if (m_tdata[21:11] !== want.col)
                    report_mismatch("out_col", int'(m_tdata[21:11]), int'(want.col));
                if (m_tdata[39:22] !== want.value)
                    report_mismatch("value_quarters", int'(m_tdata[39:22]), int'(want.value));
                if (m_tlast !== want.last_run)
                    report_mismatch("last_of_run", int'(m_tlast), int'(want.last_run));
                if (m_tuser !== want.last_frame)
                    report_mismatch("last_of_frame", int'(m_tuser), int'(want.last_frame));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("bilinear_upsample_2x_core test failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Receiver: random ready, one long hold-off so the core backs up and
    // drops s_tready while the sender keeps offering beats
    // ---------------------------------------------------------------------
    initial
    begin : point_sink
        int hold;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            if (!long_hold_done && samples_accepted >= HOLD_AFTER)
            begin
                hold           = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            else
                hold = calm ? 0 : idle_length();
            if (hold > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial
    begin : stimulus
        int                 phase;
        int                 sent;
        int                 count;
        logic [REG_W-1:0]   rows;
        logic [REG_W-1:0]   cols;
        phase = 0;
        sent  = 0;

        // reset held from time zero, then released on an edge
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (SCRIPT[k])
        begin
            if (SCRIPT[k].kind == STEP_WRITE)
                write_register(SCRIPT[k].index, SCRIPT[k].value[REG_W-1:0]);
            else
                offer_sample(SCRIPT[k].value, SCRIPT[k].pinned, SCRIPT[k].pin_row,
                             SCRIPT[k].pin_col, SCRIPT[k].pin_value);
        end

        // register extremes; large sizes get a short partial frame only
        run_phase(REG_W'(2047), REG_W'(2), 24);     // rows held at the maximum
        run_phase(REG_W'(2), REG_W'(2047), 24);     // cols held at the maximum
        run_phase(REG_W'(MAX_ROWS), REG_W'(MAX_COLS), 10);
        run_phase(REG_W'(0), REG_W'(1), 8);         // both act as two: two frames
        sent = 66;

        // random small frames, whole and partial, some phases with no idling
        while (sent < RANDOM_ITEMS)
        begin
            phase++;
            calm = (phase % 4 == 3);
            rows = ($urandom_range(0, 9) == 0) ? REG_W'($urandom_range(0, 1))
                                               : REG_W'($urandom_range(2, 6));
            cols = ($urandom_range(0, 9) == 0) ? REG_W'($urandom_range(0, 1))
                                               : REG_W'($urandom_range(2, 9));
            count = effective_size(rows, MAX_ROWS) * effective_size(cols, MAX_COLS)
                  * $urandom_range(1, 2) + $urandom_range(0, 4);
            if (count > RANDOM_ITEMS - sent)
                count = RANDOM_ITEMS - sent;
            run_phase(rows, cols, count);
            sent += count;
        end
        calm = 1'b0;

        drain_block();
        if (mismatch_count == 0)
            $display("bilinear_upsample_2x_core test passed");
        else
            $display("bilinear_upsample_2x_core test failed");
        $finish;
    end

endmodule
